>>> sv/bce_pkg.sv
package bce_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int ADC_W      = 12;
    localparam int MV_W       = 15;
    localparam int PCT_W      = 7;
    localparam int SUM_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam int CURVE_POINTS_DEF = 11;
    localparam int ADC_BITS_DEF     = 12;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_FULL_CODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_MV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV       = 3'd4;

    localparam logic [SAMPLE_W-1:0] SAMPLE_COUNT_RST  = 8'd8;
    localparam logic [ADC_W-1:0]    ADC_FULL_CODE_RST = 12'd4095;
    localparam logic [MV_W-1:0]     FULL_SCALE_MV_RST = 15'd6600;
    localparam logic [MV_W-1:0]     EMPTY_MV_RST      = 15'd2800;
    localparam logic [MV_W-1:0]     FULL_MV_RST       = 15'd4200;

    localparam logic [MV_W-1:0]  VOLT_SAT = 15'd20000;
    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;
    localparam logic [PCT_W-1:0] PCT_MIN  = 7'd0;

    // sum * full_scale, count * adc_full_code
    localparam int NUM_W = SUM_W + MV_W;
    localparam int DEN_W = SAMPLE_W + ADC_W;

    // serial divider: full voltage divide and short percentage divide
    localparam int DIV_NW = NUM_W + 2;
    localparam int DIV_DW = DEN_W + 1;
    localparam int DIV_SW = 24;
    localparam int PROD_W = PCT_W + MV_W;

    localparam int INNER_COUNT = 9;
    localparam int INNER_K_W   = 4;

    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] taken;
    } acc_snap_t;

    typedef struct packed {
        logic              start;
        logic              short_op;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } div_rsp_t;

    function automatic logic [MV_W-1:0] inner_mv(logic [INNER_K_W-1:0] k);
        logic [MV_W-1:0] r;
        case (k)
            4'd0:    r = 15'd2950;
            4'd1:    r = 15'd3100;
            4'd2:    r = 15'd3200;
            4'd3:    r = 15'd3300;
            4'd4:    r = 15'd3450;
            4'd5:    r = 15'd3600;
            4'd6:    r = 15'd3700;
            4'd7:    r = 15'd3800;
            default: r = 15'd3900;
        endcase
        return r;
    endfunction

    function automatic logic [PCT_W-1:0] inner_pct(logic [INNER_K_W-1:0] k);
        logic [PCT_W-1:0] r;
        case (k)
            4'd0:    r = 7'd5;
            4'd1:    r = 7'd10;
            4'd2:    r = 7'd15;
            4'd3:    r = 7'd25;
            4'd4:    r = 7'd40;
            4'd5:    r = 7'd55;
            4'd6:    r = 7'd70;
            4'd7:    r = 7'd85;
            default: r = 7'd96;
        endcase
        return r;
    endfunction

endpackage

>>> sv/bce_accum.sv
module bce_accum import bce_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                beat,
    input  logic [ADC_W-1:0]    sample,
    input  logic [SAMPLE_W-1:0] sample_count,
    output logic                fire,
    output acc_snap_t           snap
);

    localparam int KEEP_W = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
    localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((33'd1 << KEEP_W) - 33'd1);

    logic [SUM_W-1:0]    sum_reg,   sum_next,   sum_add;
    logic [SAMPLE_W-1:0] taken_reg, taken_next, taken_add;
    logic [SAMPLE_W-1:0] target;

    always_comb begin
        sum_add   = sum_reg + SUM_W'(sample & ADC_MASK);
        taken_add = taken_reg + SAMPLE_W'(1);
        target    = (sample_count == '0) ? SAMPLE_W'(1) : sample_count;
        fire      = beat && (taken_add >= target);
        snap.sum   = sum_add;
        snap.taken = taken_add;
        if (fire) begin
            sum_next   = '0;
            taken_next = '0;
        end else if (beat) begin
            sum_next   = sum_add;
            taken_next = taken_add;
        end else begin
            sum_next   = sum_reg;
            taken_next = taken_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            taken_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            taken_reg <= taken_next;
        end
    end

endmodule

>>> sv/bce_div.sv
module bce_div import bce_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dvs_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW:0]   trial;
    logic              ge;
    logic [DIV_DW-1:0] rem_step;

    always_comb begin
        trial    = {rem_reg, quo_reg[DIV_NW-1]};
        ge       = trial >= {1'b0, dvs_reg};
        rem_step = ge ? DIV_DW'(trial - {1'b0, dvs_reg}) : trial[DIV_DW-1:0];
        done_next = busy_reg && (cnt_reg == CNT_W'(1));
        if (req.start) begin
            busy_next = 1'b1;
        end else if (done_next) begin
            busy_next = 1'b0;
        end else begin
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // short op: dividend fits DIV_SW bits, skip the leading zero steps
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            if (req.short_op) begin
                quo_reg <= req.dividend << (DIV_NW - DIV_SW);
                cnt_reg <= CNT_W'(DIV_SW);
            end else begin
                quo_reg <= req.dividend;
                cnt_reg <= CNT_W'(DIV_NW);
            end
        end else if (busy_reg) begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[DIV_NW-2:0], ge};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> sv/battery_charge_estimator.sv
// Samples that do not complete a reading are taken one per cycle while the block is idle.
// The sample that completes a reading starts a run: a 37-step bit-serial divide for the
// voltage, a curve walk of one point per cycle and, for a voltage inside a rising curve
// segment, a 24-step divide for the percentage; no sample is taken during that run.
// A finished result waits in an output register while the next samples are taken.
// Reset (synchronous, aresetn low) clears sum, count and m_valid, loads register defaults.
module battery_charge_estimator import bce_pkg::*; #(
    parameter int CURVE_POINTS = CURVE_POINTS_DEF,
    parameter int ADC_BITS     = ADC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ADC_W-1:0]      s_adc_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [MV_W-1:0]       m_voltage_mv,
    output logic [PCT_W-1:0]      m_charge_percent
);

    localparam int IDX_W = $clog2(CURVE_POINTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CURVE_POINTS - 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL    = 4'd1;
    localparam logic [3:0] ST_VSTART = 4'd2;
    localparam logic [3:0] ST_VWAIT  = 4'd3;
    localparam logic [3:0] ST_SEARCH = 4'd4;
    localparam logic [3:0] ST_PMUL   = 4'd5;
    localparam logic [3:0] ST_PSTART = 4'd6;
    localparam logic [3:0] ST_PWAIT  = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0] state_reg, state_next;

    logic [SAMPLE_W-1:0] sample_count_reg;
    logic [ADC_W-1:0]    adc_full_code_reg;
    logic [MV_W-1:0]     full_scale_mv_reg;
    logic [MV_W-1:0]     empty_mv_reg;
    logic [MV_W-1:0]     full_mv_reg;

    logic [SUM_W-1:0]    sum_cap_reg;
    logic [SAMPLE_W-1:0] taken_cap_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DIV_NW-1:0]   mv_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [MV_W-1:0]     lv_reg;
    logic [PCT_W-1:0]    lp_reg;
    logic [PCT_W-1:0]    up_reg;
    logic [MV_W-1:0]     span_reg;
    logic [MV_W-1:0]     d_reg;
    logic [PROD_W-1:0]   p1_reg;
    logic [PROD_W-1:0]   p2_reg;
    logic [PCT_W-1:0]    pct_reg;

    logic                m_valid_reg, m_valid_next;
    logic [MV_W-1:0]     m_volt_reg;
    logic [PCT_W-1:0]    m_pct_reg;

    logic                beat;
    logic                fire;
    acc_snap_t           snap;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic [ADC_W-1:0]     afc_eff;
    logic [IDX_W-1:0]     k_full;
    logic [INNER_K_W-1:0] k;
    logic [MV_W-1:0]      pt_mv;
    logic [PCT_W-1:0]     pt_pct;
    logic                 v_le_pt;
    logic [MV_W:0]        span_s;
    logic                 span_nonpos;
    logic [PROD_W:0]      psum;
    logic [DIV_SW-1:0]    pdiv;
    logic                 out_free;

    assign beat     = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    bce_accum #(
        .ADC_BITS(ADC_BITS)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat        (beat),
        .sample      (s_adc_sample),
        .sample_count(sample_count_reg),
        .fire        (fire),
        .snap        (snap)
    );

    bce_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    // curve point at idx_reg
    always_comb begin
        afc_eff = (adc_full_code_reg == '0) ? ADC_W'(1) : adc_full_code_reg;
        k_full  = idx_reg - IDX_W'(1);
        k       = (int'(k_full) >= INNER_COUNT) ? INNER_K_W'(INNER_COUNT - 1)
                                                 : INNER_K_W'(k_full);
        if (idx_reg == '0) begin
            pt_mv  = empty_mv_reg;
            pt_pct = PCT_MIN;
        end else if (idx_reg >= LAST_IDX) begin
            pt_mv  = full_mv_reg;
            pt_pct = PCT_MAX;
        end else begin
            pt_mv  = inner_mv(k);
            pt_pct = inner_pct(k);
        end
        v_le_pt     = mv_reg <= DIV_NW'(pt_mv);
        span_s      = {1'b0, pt_mv} - {1'b0, lv_reg};
        span_nonpos = span_s[MV_W] || (span_s == '0);
        psum        = (PROD_W + 1)'(p1_reg) + (PROD_W + 1)'(p2_reg);
        pdiv        = DIV_SW'({psum, 1'b0}) + DIV_SW'(span_reg);

        div_req.start    = (state_reg == ST_VSTART) || (state_reg == ST_PSTART);
        div_req.short_op = (state_reg == ST_PSTART);
        if (state_reg == ST_PSTART) begin
            div_req.dividend = DIV_NW'(pdiv);
            div_req.divisor  = DIV_DW'({span_reg, 1'b0});
        end else begin
            div_req.dividend = DIV_NW'({num_reg, 1'b0}) + DIV_NW'(den_reg);
            div_req.divisor  = {den_reg, 1'b0};
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (fire) state_next = ST_MUL;
            ST_MUL:    state_next = ST_VSTART;
            ST_VSTART: state_next = ST_VWAIT;
            ST_VWAIT:  if (div_rsp.done) state_next = ST_SEARCH;
            ST_SEARCH: begin
                if (idx_reg == '0) begin
                    if (v_le_pt) state_next = ST_DONE;
                end else if (!v_le_pt) begin
                    if (idx_reg >= LAST_IDX) state_next = ST_DONE;
                end else if (span_nonpos) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL:   state_next = ST_PSTART;
            ST_PSTART: state_next = ST_PWAIT;
            ST_PWAIT:  if (div_rsp.done) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase

        if ((state_reg == ST_DONE) && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_valid_reg       <= 1'b0;
            sample_count_reg  <= SAMPLE_COUNT_RST;
            adc_full_code_reg <= ADC_FULL_CODE_RST;
            full_scale_mv_reg <= FULL_SCALE_MV_RST;
            empty_mv_reg      <= EMPTY_MV_RST;
            full_mv_reg       <= FULL_MV_RST;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_SAMPLE_COUNT:  sample_count_reg  <= cfg_wdata[SAMPLE_W-1:0];
                    REG_ADC_FULL_CODE: adc_full_code_reg <= cfg_wdata[ADC_W-1:0];
                    REG_FULL_SCALE_MV: full_scale_mv_reg <= cfg_wdata[MV_W-1:0];
                    REG_EMPTY_MV:      empty_mv_reg      <= cfg_wdata[MV_W-1:0];
                    REG_FULL_MV:       full_mv_reg       <= cfg_wdata[MV_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (fire) begin
                    sum_cap_reg   <= snap.sum;
                    taken_cap_reg <= snap.taken;
                end
            end
            ST_MUL: begin
                num_reg <= NUM_W'(sum_cap_reg) * NUM_W'(full_scale_mv_reg);
                den_reg <= DEN_W'(taken_cap_reg) * DEN_W'(afc_eff);
            end
            ST_VWAIT: begin
                if (div_rsp.done) begin
                    mv_reg  <= div_rsp.quotient;
                    idx_reg <= '0;
                end
            end
            ST_SEARCH: begin
                if (idx_reg == '0) begin
                    if (v_le_pt) begin
                        pct_reg <= PCT_MIN;
                    end else begin
                        lv_reg  <= pt_mv;
                        lp_reg  <= pt_pct;
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end else if (!v_le_pt) begin
                    lv_reg  <= pt_mv;
                    lp_reg  <= pt_pct;
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg >= LAST_IDX) pct_reg <= PCT_MAX;
                end else if (span_nonpos) begin
                    pct_reg <= pt_pct;
                end else begin
                    span_reg <= span_s[MV_W-1:0];
                    d_reg    <= mv_reg[MV_W-1:0] - lv_reg;
                    up_reg   <= pt_pct;
                end
            end
            ST_PMUL: begin
                p1_reg <= PROD_W'(lp_reg) * PROD_W'(span_reg);
                p2_reg <= PROD_W'(d_reg) * PROD_W'(up_reg - lp_reg);
            end
            ST_PWAIT: begin
                if (div_rsp.done) begin
                    pct_reg <= (div_rsp.quotient > DIV_NW'(PCT_MAX)) ? PCT_MAX
                                                                    : div_rsp.quotient[PCT_W-1:0];
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_volt_reg <= (mv_reg > DIV_NW'(VOLT_SAT)) ? VOLT_SAT : mv_reg[MV_W-1:0];
                    m_pct_reg  <= pct_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_voltage_mv     = m_volt_reg;
    assign m_charge_percent = m_pct_reg;

endmodule

>>> verif/battery_charge_estimator_checker.sv
module battery_charge_estimator_checker import bce_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [ADC_W-1:0]      s_adc_sample,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [MV_W-1:0]       m_voltage_mv,
    input  logic [PCT_W-1:0]      m_charge_percent,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [MV_W-1:0]  voltage_mv;
        logic [PCT_W-1:0] charge_percent;
    } reading_t;

    reading_t readings_due[$];

    logic [SAMPLE_W-1:0] avg_len;
    logic [ADC_W-1:0]    code_full;
    logic [MV_W-1:0]     scale_mv;
    logic [MV_W-1:0]     low_knee_mv;
    logic [MV_W-1:0]     high_knee_mv;
    logic [SUM_W-1:0]    code_sum;
    logic [SAMPLE_W-1:0] code_cnt;

    function automatic void curve_point(input int i, output longint mv, output longint pct);
        case (i)
            0:       begin mv = low_knee_mv; pct = 0;  end
            1:       begin mv = 2950;        pct = 5;  end
            2:       begin mv = 3100;        pct = 10; end
            3:       begin mv = 3200;        pct = 15; end
            4:       begin mv = 3300;        pct = 25; end
            5:       begin mv = 3450;        pct = 40; end
            6:       begin mv = 3600;        pct = 55; end
            7:       begin mv = 3700;        pct = 70; end
            8:       begin mv = 3800;        pct = 85; end
            9:       begin mv = 3900;        pct = 96; end
            default: begin mv = high_knee_mv; pct = 100; end
        endcase
    endfunction

    function automatic longint pct_clamp(input longint p);
        if (p < 0) return 0;
        if (p > 100) return 100;
        return p;
    endfunction

    function automatic longint soc_percent(input longint v);
        longint lv, lp, uv, up, span, d, num;
        int     i;
        lv = low_knee_mv;
        lp = 0;
        if (v <= lv) return 0;
        for (i = 1; i < CURVE_POINTS_DEF; i++) begin
            curve_point(i, uv, up);
            if (v > uv) begin
                lv = uv;
                lp = up;
            end else begin
                span = uv - lv;
                if (span <= 0) return pct_clamp(up);
                d = v - lv;
                if (d < 0) d = 0;
                if (d > span) d = span;
                num = 2 * (lp * span + d * (up - lp)) + span;
                if (num < 0) return 0;
                return pct_clamp(num / (2 * span));
            end
        end
        return 100;
    endfunction

    always @(posedge aclk) begin : monitor
        logic [SAMPLE_W-1:0] target;
        longint   num, den, mv, pct;
        reading_t want, got;
        if (!aresetn) begin
            avg_len      = SAMPLE_COUNT_RST;
            code_full    = ADC_FULL_CODE_RST;
            scale_mv     = FULL_SCALE_MV_RST;
            low_knee_mv  = EMPTY_MV_RST;
            high_knee_mv = FULL_MV_RST;
            code_sum     = '0;
            code_cnt     = '0;
            fail_count   = 0;
            readings_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SAMPLE_COUNT:  avg_len      = cfg_wdata[SAMPLE_W-1:0];
                    REG_ADC_FULL_CODE: code_full    = cfg_wdata[ADC_W-1:0];
                    REG_FULL_SCALE_MV: scale_mv     = cfg_wdata[MV_W-1:0];
                    REG_EMPTY_MV:      low_knee_mv  = cfg_wdata[MV_W-1:0];
                    REG_FULL_MV:       high_knee_mv = cfg_wdata[MV_W-1:0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                got.voltage_mv     = m_voltage_mv;
                got.charge_percent = m_charge_percent;
                if (readings_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: voltage_mv=%0d charge_percent=%0d",
                                 got.voltage_mv, got.charge_percent);
                end else begin
                    want = readings_due.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected mv=%0d pct=%0d, got mv=%0d pct=%0d",
                                     want.voltage_mv, want.charge_percent,
                                     got.voltage_mv, got.charge_percent);
                    end
                end
            end

            if (s_valid && s_ready) begin
                target   = (avg_len == 0) ? SAMPLE_W'(1) : avg_len;
                code_sum = code_sum + SUM_W'(s_adc_sample);
                code_cnt = code_cnt + 1'b1;
                if (code_cnt >= target) begin
                    den = longint'(code_cnt)
                        * longint'((code_full == 0) ? ADC_W'(1) : code_full);
                    num = longint'(code_sum) * longint'(scale_mv);
                    mv  = (2 * num + den) / (2 * den);
                    pct = soc_percent(mv);
                    want.voltage_mv     = (mv > longint'(VOLT_SAT)) ? VOLT_SAT : mv[MV_W-1:0];
                    want.charge_percent = pct[PCT_W-1:0];
                    readings_due.push_back(want);
                    code_sum = '0;
                    code_cnt = '0;
                end
            end
        end
        pending = readings_due.size();
    end

endmodule

>>> verif/tb_battery_charge_estimator.sv
module tb_battery_charge_estimator import bce_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 100;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [ADC_W-1:0]      s_adc_sample;
    logic                  m_valid;
    logic                  m_ready;
    logic [MV_W-1:0]       m_voltage_mv;
    logic [PCT_W-1:0]      m_charge_percent;

    int fail_count;
    int pending;
    int tx_idle  = 0;
    int rx_stall = 0;
    int quiet_cycles = 0;
    longint code_full_eff;
    longint scale_eff;

    battery_charge_estimator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_adc_sample     (s_adc_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_voltage_mv     (m_voltage_mv),
        .m_charge_percent (m_charge_percent)
    );

    battery_charge_estimator_checker u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_adc_sample     (s_adc_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_voltage_mv     (m_voltage_mv),
        .m_charge_percent (m_charge_percent),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= rx_stall);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("FAIL battery_charge_estimator");
                $finish;
            end
        end
    end

    // register write beat; caller lowers the enable after the last one
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] cnt_w,
                                 input logic [CFG_DATA_W-1:0] afc_w,
                                 input logic [CFG_DATA_W-1:0] fs_w,
                                 input logic [CFG_DATA_W-1:0] em_w,
                                 input logic [CFG_DATA_W-1:0] fm_w);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_write(REG_SAMPLE_COUNT, cnt_w);
        cfg_write(REG_ADC_FULL_CODE, afc_w);
        cfg_write(REG_FULL_SCALE_MV, fs_w);
        cfg_write(REG_EMPTY_MV, em_w);
        cfg_write(REG_FULL_MV, fm_w);
        cfg_wr_en = 1'b0;
        code_full_eff = (afc_w[ADC_W-1:0] == 0) ? 1 : longint'(afc_w[ADC_W-1:0]);
        scale_eff     = (fs_w == 0) ? 1 : longint'(fs_w);
    endtask

    task automatic drive_sample(input logic [ADC_W-1:0] code);
        while ($urandom_range(99) < tx_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_adc_sample = code;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // mostly codes that land on the charge curve, some raw noise and rails
    function automatic logic [ADC_W-1:0] pick_sample();
        int     r, jit;
        longint c;
        r = $urandom_range(99);
        if (r < 4) return r[0] ? {ADC_W{1'b1}} : {ADC_W{1'b0}};
        if (r < 30) return ADC_W'($urandom_range(4095));
        jit = $urandom_range(6);
        c = (longint'($urandom_range(2500, 4600)) * code_full_eff) / scale_eff + jit - 3;
        if (c < 0) c = 0;
        if (c > 4095) c = 4095;
        return c[ADC_W-1:0];
    endfunction

    task automatic run_phase(input int p);
        logic [CFG_DATA_W-1:0] cnt_w, afc_w, fs_w, em_w, fm_w;
        int n_items, i;
        case (p % 4)
            0:       begin tx_idle = 0;  rx_stall = 0;  end
            1:       begin tx_idle = 84; rx_stall = 0;  end
            2:       begin tx_idle = 0;  rx_stall = 84; end
            default: begin tx_idle = 9;  rx_stall = 9;  end
        endcase
        n_items = 160;
        if (p == 4) begin
            cnt_w   = {7'($urandom), 8'd255};
            n_items = 600;
        end else if (p == 7) begin
            cnt_w = {7'($urandom), 8'd0};
        end else if ($urandom_range(3) == 0) begin
            cnt_w = {7'($urandom), 8'($urandom_range(5, 32))};
        end else begin
            cnt_w = {7'($urandom), 8'($urandom_range(1, 4))};
        end
        afc_w = {3'($urandom), 12'($urandom_range(1, 4095))};
        fs_w  = 15'($urandom_range(3000, 20000));
        em_w  = 15'($urandom_range(2000, 3100));
        fm_w  = 15'($urandom_range(3700, 5000));
        case (p)
            0: begin afc_w[ADC_W-1:0] = 12'd1; fs_w = 15'd1; em_w = 15'd0; fm_w = 15'd0; end
            1: begin
                afc_w[ADC_W-1:0] = 12'd4095;
                fs_w = 15'd20000;
                em_w = 15'd20000;
                fm_w = 15'd20000;
            end
            2: begin afc_w[ADC_W-1:0] = 12'd0; fs_w = 15'h7fff; em_w = 15'd3000; fm_w = 15'd3850; end
            5: begin fs_w = 15'd0; em_w = 15'd0; fm_w = 15'h7fff; end
            6: begin em_w = 15'd4000; fm_w = 15'd3000; end
            default: ;
        endcase
        load_settings(cnt_w, afc_w, fs_w, em_w, fm_w);
        for (i = 0; i < n_items; i++) drive_sample(pick_sample());
        s_valid = 1'b0;
    endtask

    initial begin : stimulus
        int p;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_adc_sample = '0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // one sample per reading, code maps straight to millivolts
        load_settings(15'd1, 15'd4095, 15'd4095, 15'd2800, 15'd4000);
        cfg_write(REG_UNUSED, 15'h7fff);
        cfg_wr_en = 1'b0;
        drive_sample(12'd0);
        drive_sample(12'd2800);
        drive_sample(12'd2801);
        drive_sample(12'd2875);
        drive_sample(12'd2950);
        drive_sample(12'd3025);
        drive_sample(12'd3150);
        drive_sample(12'd3375);
        drive_sample(12'd3899);
        drive_sample(12'd3900);
        drive_sample(12'd3950);
        drive_sample(12'd4000);
        drive_sample(12'd4001);
        drive_sample(12'd4095);
        s_valid = 1'b0;

        // zero count and zero full code, plus saturation
        load_settings(15'd0, 15'd0, 15'd20000, 15'd2800, 15'd4200);
        drive_sample(12'd4095);
        drive_sample(12'd0);
        s_valid = 1'b0;

        // count lowered while a reading is partly summed
        load_settings(15'd8, 15'd4095, 15'd6600, 15'd2800, 15'd4200);
        repeat (5) drive_sample(12'($urandom_range(1700, 2700)));
        s_valid = 1'b0;
        load_settings(15'd3, 15'd4095, 15'd6600, 15'd2800, 15'd4200);
        drive_sample(12'($urandom_range(1700, 2700)));
        s_valid = 1'b0;

        for (p = 0; p < 10; p++) run_phase(p);

        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (fail_count == 0) begin
            $display("PASS battery_charge_estimator");
        end else begin
            $display("FAIL battery_charge_estimator");
        end
        $finish;
    end

endmodule

>>> battery_charge_estimator.f
sv/bce_pkg.sv
sv/bce_accum.sv
sv/bce_div.sv
sv/battery_charge_estimator.sv
verif/battery_charge_estimator_checker.sv
verif/tb_battery_charge_estimator.sv
